### rtl/lcdtc_pkg.sv
// ----------------------------------------------------------------------------
// lcdtc_pkg: shared types and constants for the character LCD tick controller
// Item structs, mode, status and register index codes, command bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcdtc_pkg;

  localparam int unsigned MaxLen   = 32;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CfgIdxW  = 2;

  // input modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_LOAD  = 2'd3;

  // status codes
  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_INIT_DELAY  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLEAR_DELAY = 2'd1;

  localparam logic [7:0] DELAY_RESET = 8'd50;

  // LCD command bytes
  localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_LINE0     = 8'h80;
  localparam logic [7:0] CMD_LINE1     = 8'hC0;

  typedef struct packed {
    logic [1:0] mode;
    logic       row;
    logic [5:0] column;
    logic [5:0] length;
    logic [4:0] char_slot;
    logic [7:0] char_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       rs_level;
    logic       enable_level;
    logic [7:0] bus_value;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/lcdtc_ctl.sv
// ----------------------------------------------------------------------------
// lcdtc_ctl: sequencer, pin levels, request latch and character buffer
// Applies one accepted beat to the state and presents the resulting pins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdtc_ctl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           acc_i,
  input  wire lcdtc_pkg::in_item_t            item_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [lcdtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  output lcdtc_pkg::out_item_t                res_o
);
  import lcdtc_pkg::*;

  localparam logic [3:0] PH_SETUP   = 4'd0;
  localparam logic [3:0] PH_WAIT1   = 4'd1;
  localparam logic [3:0] PH_C38     = 4'd2;
  localparam logic [3:0] PH_C0C     = 4'd3;
  localparam logic [3:0] PH_C06     = 4'd4;
  localparam logic [3:0] PH_C01     = 4'd5;
  localparam logic [3:0] PH_WAIT2   = 4'd6;
  localparam logic [3:0] PH_FINISH  = 4'd7;
  localparam logic [3:0] PH_READY   = 4'd8;
  localparam logic [3:0] PH_CURSOR  = 4'd9;
  localparam logic [3:0] PH_DATA    = 4'd10;
  localparam logic [3:0] PH_CLRCMD  = 4'd11;
  localparam logic [3:0] PH_CLRWAIT = 4'd12;

  logic [7:0] init_delay_q, clear_delay_q;
  logic [3:0] phase_q, phase_d;
  logic [7:0] wait_q, wait_d;
  logic       strobe_q, strobe_d;
  logic [5:0] ptr_q, ptr_d;
  logic       row_q, row_d;
  logic [5:0] col_q, col_d;
  logic [5:0] len_q, len_d;
  logic [9:0] pins_q, pins_d;
  logic [7:0] text_q [MaxLen];

  logic       is_tick;
  logic       strobe_act, wait_act, wait_done, data_more;
  logic       sel_rs;
  logic [7:0] sel_byte, wait_lim, cursor_byte;
  logic       load_we;
  logic [5:0] req_len;

  assign is_tick     = acc_i && (item_i.mode == MODE_TICK);
  assign data_more   = ptr_q < len_q;
  assign cursor_byte = (row_q ? CMD_LINE1 : CMD_LINE0) + {2'b00, col_q};
  assign wait_lim    = (phase_q == PH_CLRWAIT) ? clear_delay_q : init_delay_q;
  assign wait_done   = wait_q >= wait_lim;
  assign load_we     = acc_i && (item_i.mode == MODE_LOAD)
                       && ({1'b0, item_i.char_slot} < 6'(MaxLen));
  assign req_len     = (item_i.length > 6'(MaxLen)) ? 6'(MaxLen) : item_i.length;

  // byte and RS for whichever transfer the current phase drives
  always_comb begin
    strobe_act = 1'b1;
    wait_act   = 1'b0;
    sel_rs     = 1'b0;
    sel_byte   = CMD_CLEAR;
    unique case (phase_q)
      PH_C38:     sel_byte = CMD_FUNC_SET;
      PH_C0C:     sel_byte = CMD_DISP_ON;
      PH_C06:     sel_byte = CMD_ENTRY;
      PH_C01:     sel_byte = CMD_CLEAR;
      PH_CLRCMD:  sel_byte = CMD_CLEAR;
      PH_CURSOR:  sel_byte = cursor_byte;
      PH_DATA: begin
        strobe_act = data_more;
        sel_rs     = 1'b1;
        sel_byte   = text_q[ptr_q[SlotW-1:0]];
      end
      PH_WAIT1, PH_WAIT2, PH_CLRWAIT: begin
        strobe_act = 1'b0;
        wait_act   = 1'b1;
      end
      default:    strobe_act = 1'b0;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    wait_d   = wait_q;
    strobe_d = strobe_q;
    ptr_d    = ptr_q;
    row_d    = row_q;
    col_d    = col_q;
    len_d    = len_q;
    pins_d   = pins_q;

    if (is_tick) begin
      // shared transfer step: E high with the byte, then E low
      if (strobe_act) begin
        if (!strobe_q) begin
          pins_d   = {sel_rs, 1'b1, sel_byte};
          strobe_d = 1'b1;
        end else begin
          pins_d[8] = 1'b0;
          strobe_d  = 1'b0;
        end
      end
      if (wait_act) begin
        wait_d = wait_done ? 8'd0 : wait_q + 8'd1;
      end

      unique case (phase_q)
        PH_SETUP:   phase_d = PH_WAIT1;
        PH_WAIT1:   if (wait_done) phase_d = PH_C38;
        PH_C38:     if (strobe_q) phase_d = PH_C0C;
        PH_C0C:     if (strobe_q) phase_d = PH_C06;
        PH_C06:     if (strobe_q) phase_d = PH_C01;
        PH_C01:     if (strobe_q) phase_d = PH_WAIT2;
        PH_WAIT2:   if (wait_done) phase_d = PH_FINISH;
        PH_FINISH:  phase_d = PH_READY;
        PH_CURSOR:  if (strobe_q) phase_d = PH_DATA;
        PH_DATA: begin
          if (data_more) begin
            if (strobe_q) ptr_d = ptr_q + 6'd1;
          end else begin
            ptr_d   = 6'd0;
            phase_d = PH_READY;
          end
        end
        PH_CLRCMD:  if (strobe_q) phase_d = PH_CLRWAIT;
        PH_CLRWAIT: if (wait_done) phase_d = PH_READY;
        default:    phase_d = phase_q;
      endcase
    end else if (acc_i && (phase_q == PH_READY)) begin
      if (item_i.mode == MODE_WRITE) begin
        row_d   = item_i.row;
        col_d   = item_i.column;
        len_d   = req_len;
        ptr_d   = 6'd0;
        phase_d = PH_CURSOR;
      end else if (item_i.mode == MODE_CLEAR) begin
        wait_d  = 8'd0;
        phase_d = PH_CLRCMD;
      end
    end
  end

  always_comb begin
    if (phase_d < PH_READY) begin
      res_o.status = ST_INIT;
    end else if (phase_d == PH_READY) begin
      res_o.status = ST_READY;
    end else begin
      res_o.status = ST_BUSY;
    end
    res_o.rs_level     = pins_d[9];
    res_o.enable_level = pins_d[8];
    res_o.bus_value    = pins_d[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_delay_q  <= DELAY_RESET;
      clear_delay_q <= DELAY_RESET;
      phase_q       <= PH_SETUP;
      wait_q        <= 8'd0;
      strobe_q      <= 1'b0;
      ptr_q         <= 6'd0;
      row_q         <= 1'b0;
      col_q         <= 6'd0;
      len_q         <= 6'd0;
      pins_q        <= 10'd0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_INIT_DELAY)) init_delay_q <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == CFG_CLEAR_DELAY)) clear_delay_q <= cfg_data_i;
      phase_q  <= phase_d;
      wait_q   <= wait_d;
      strobe_q <= strobe_d;
      ptr_q    <= ptr_d;
      row_q    <= row_d;
      col_q    <= col_d;
      len_q    <= len_d;
      pins_q   <= pins_d;
    end
  end

  // character buffer, contents undefined until loaded
  always_ff @(posedge clk_i) begin
    if (load_we) text_q[item_i.char_slot] <= item_i.char_value;
  end

endmodule

`default_nettype wire

### rtl/lcdtc_out_buf.sv
// ----------------------------------------------------------------------------
// lcdtc_out_buf: two-entry result buffer
// Registers each result beat and decouples input stall from output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdtc_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire lcdtc_pkg::out_item_t data_i,
  output logic                      full_o,
  output logic                      valid_o,
  input  wire logic                 stall_i,
  output lcdtc_pkg::out_item_t      data_o
);
  import lcdtc_pkg::*;

  out_item_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rd_q];
  assign pop     = valid_o && !stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

### rtl/char_lcd_tick_controller.sv
// ----------------------------------------------------------------------------
// char_lcd_tick_controller: tick-driven 8-bit character LCD controller
// Power-up sequence, cursor/character writes and clear, driven one tick a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid_i / in_stall_o) carry a mode: tick, write request,
//   clear request or load of one buffer character. Only ticks advance the
//   sequencer; each transfer tick moves the pins (bus with E high, then E low).
//   Every accepted beat yields exactly one result beat (out_valid_o /
//   out_stall_i) with status and the RS, E and bus levels after that beat.
//   Results are registered before out_valid_o; one beat per cycle is
//   sustained while out_stall_i is low; next-state logic is one short level.
//   A two-entry result buffer lets input continue while a result waits;
//   in_stall_o rises only when both entries are held by a stalled receiver.
//   Config writes (cfg_valid_i, always ready) set the power-up and clear waits;
//   the user must make them only while the block is idle; it is not enforced.
//   Reset clears the sequencer to its power-up set-up step, pins low, waits 50;
//   buffer characters are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_tick_controller (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire lcdtc_pkg::in_item_t            in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output lcdtc_pkg::out_item_t                out_item_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lcdtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i
);
  import lcdtc_pkg::*;

  logic      acc;
  logic      full;
  out_item_t res;

  assign in_stall_o  = full;
  assign acc         = in_valid_i && !full;
  assign cfg_ready_o = 1'b1;

  lcdtc_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res)
  );

  lcdtc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_item_o)
  );

endmodule

`default_nettype wire

### dv/char_lcd_tick_controller_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_tick_controller_tb: self-checking bench for the LCD tick controller
// Queue-fed driver, random stall on the result side, and a cycle-true model of
// the sequencer and pins that predicts the result of every accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_tick_controller_tb;
  import lcdtc_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned PhaseBeats  = 430;
  localparam int unsigned MaxReported = 10;

  // sequencer steps, in the order the block walks them
  typedef enum logic [3:0] {
    SEQ_POWERUP, SEQ_WAIT_INIT, SEQ_CMD_FUNC, SEQ_CMD_DISP, SEQ_CMD_ENTRY,
    SEQ_CMD_CLEAR, SEQ_WAIT_POST, SEQ_FINISH, SEQ_READY, SEQ_CURSOR,
    SEQ_TEXT, SEQ_CLR_CMD, SEQ_CLR_WAIT
  } lcd_step_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  in_item_t            in_item = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [7:0]          cfg_data = '0;

  char_lcd_tick_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // pin and sequencer model
  // --------------------------------------------------------------------------
  logic [7:0]  mdl_init_delay  = DELAY_RESET;
  logic [7:0]  mdl_clear_delay = DELAY_RESET;
  lcd_step_e   seq = SEQ_POWERUP;
  logic [7:0]  wait_cnt = '0;
  logic        e_high = 1'b0;
  logic [5:0]  text_ptr = '0;
  logic        req_row = 1'b0;
  logic [5:0]  req_col = '0;
  logic [5:0]  req_len = '0;
  logic [7:0]  text_mem [MaxLen];
  logic        pin_rs = 1'b0;
  logic        pin_e = 1'b0;
  logic [7:0]  pin_bus = '0;

  out_item_t   expected_pins_q [$];

  // one tick of a byte transfer: bus and E high, then E low
  function automatic logic strobe_pins(logic rs, logic [7:0] data);
    if (!e_high) begin
      pin_rs  = rs;
      pin_e   = 1'b1;
      pin_bus = data;
      e_high  = 1'b1;
      return 1'b0;
    end
    pin_e  = 1'b0;
    e_high = 1'b0;
    return 1'b1;
  endfunction

  // limit is read live, so a lowered delay ends a running wait at once
  function automatic logic wait_over(logic [7:0] limit);
    if (wait_cnt < limit) begin
      wait_cnt = wait_cnt + 8'd1;
      return 1'b0;
    end
    wait_cnt = '0;
    return 1'b1;
  endfunction

  function automatic void advance_tick();
    logic [7:0] cursor_addr;
    cursor_addr = (req_row ? CMD_LINE1 : CMD_LINE0) + {2'b00, req_col};
    case (seq)
      SEQ_POWERUP:   seq = SEQ_WAIT_INIT;
      SEQ_WAIT_INIT: if (wait_over(mdl_init_delay)) seq = SEQ_CMD_FUNC;
      SEQ_CMD_FUNC:  if (strobe_pins(1'b0, CMD_FUNC_SET)) seq = SEQ_CMD_DISP;
      SEQ_CMD_DISP:  if (strobe_pins(1'b0, CMD_DISP_ON)) seq = SEQ_CMD_ENTRY;
      SEQ_CMD_ENTRY: if (strobe_pins(1'b0, CMD_ENTRY)) seq = SEQ_CMD_CLEAR;
      SEQ_CMD_CLEAR: if (strobe_pins(1'b0, CMD_CLEAR)) seq = SEQ_WAIT_POST;
      SEQ_WAIT_POST: if (wait_over(mdl_init_delay)) seq = SEQ_FINISH;
      SEQ_FINISH:    seq = SEQ_READY;
      SEQ_CURSOR:    if (strobe_pins(1'b0, cursor_addr)) seq = SEQ_TEXT;
      SEQ_TEXT: begin
        if (text_ptr < req_len) begin
          if (strobe_pins(1'b1, text_mem[text_ptr[4:0]])) text_ptr = text_ptr + 6'd1;
        end else begin
          text_ptr = '0;
          seq = SEQ_READY;
        end
      end
      SEQ_CLR_CMD:   if (strobe_pins(1'b0, CMD_CLEAR)) seq = SEQ_CLR_WAIT;
      SEQ_CLR_WAIT:  if (wait_over(mdl_clear_delay)) seq = SEQ_READY;
      default: ;
    endcase
  endfunction

  function automatic void predict_beat(in_item_t b);
    out_item_t r;
    case (b.mode)
      MODE_TICK: advance_tick();
      MODE_WRITE: begin
        if (seq == SEQ_READY) begin
          req_row  = b.row;
          req_col  = b.column;
          req_len  = (b.length > MaxLen) ? 6'(MaxLen) : b.length;
          text_ptr = '0;
          seq      = SEQ_CURSOR;
        end
      end
      MODE_CLEAR: begin
        if (seq == SEQ_READY) begin
          wait_cnt = '0;
          seq      = SEQ_CLR_CMD;
        end
      end
      default: text_mem[b.char_slot] = b.char_value;
    endcase
    if (seq < SEQ_READY) r.status = ST_INIT;
    else if (seq == SEQ_READY) r.status = ST_READY;
    else r.status = ST_BUSY;
    r.rs_level     = pin_rs;
    r.enable_level = pin_e;
    r.bus_value    = pin_bus;
    expected_pins_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // driver, result stall and monitor
  // --------------------------------------------------------------------------
  in_item_t     pending_beats [$];
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_stall_pct = 0;
  int unsigned  results_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  holdoff_left = 0;
  logic         holdoff_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) predict_beat(in_item);
      if (!in_valid || !in_stall_o) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_item  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off early on backs the block up until it stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && results_seen >= 150) begin
      out_stall    <= 1'b1;
      holdoff_left <= 120;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_pins_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result beat: status=%0d rs=%0b e=%0b bus=%02h",
                   out_item_o.status, out_item_o.rs_level, out_item_o.enable_level,
                   out_item_o.bus_value);
      end else begin
        want = expected_pins_q.pop_front();
        if (out_item_o.status !== want.status || out_item_o.rs_level !== want.rs_level ||
            out_item_o.enable_level !== want.enable_level ||
            out_item_o.bus_value !== want.bus_value) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("result %0d: expected status=%0d rs=%0b e=%0b bus=%02h, %s%0d %s%0b %s%0b %s%02h",
                     results_seen, want.status, want.rs_level, want.enable_level,
                     want.bus_value, "got status=", out_item_o.status, "rs=",
                     out_item_o.rs_level, "e=", out_item_o.enable_level, "bus=",
                     out_item_o.bus_value);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  logic [MaxLen-1:0] slot_loaded = '0;
  int unsigned       beats_queued = 0;

  function automatic in_item_t rand_item(logic [1:0] mode);
    in_item_t it;
    it.mode       = mode;
    it.row        = 1'($urandom_range(0, 1));
    it.column     = 6'($urandom_range(0, 63));
    it.length     = 6'($urandom_range(0, 63));
    it.char_slot  = 5'($urandom_range(0, 31));
    it.char_value = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // only lengths whose slots are all loaded, so no unwritten entry is read
  function automatic logic [5:0] pick_length();
    int unsigned filled;
    filled = 0;
    while (filled < MaxLen && slot_loaded[filled]) filled++;
    if (filled < MaxLen) return 6'($urandom_range(0, filled));
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 12));
  endfunction

  function automatic logic [4:0] pick_slot();
    int unsigned s;
    s = 0;
    while (s < MaxLen && slot_loaded[s]) s++;
    if (s == MaxLen || $urandom_range(0, 1) == 0) return 5'($urandom_range(0, 31));
    return 5'(s);
  endfunction

  task automatic push_ticks(int unsigned n);
    repeat (n) begin
      pending_beats.push_back(rand_item(MODE_TICK));
      beats_queued++;
    end
  endtask

  task automatic push_load(logic [4:0] slot, logic [7:0] value);
    in_item_t it;
    it = rand_item(MODE_LOAD);
    it.char_slot  = slot;
    it.char_value = value;
    slot_loaded[slot] = 1'b1;
    pending_beats.push_back(it);
    beats_queued++;
  endtask

  task automatic push_write(logic row, logic [5:0] column, logic [5:0] length);
    in_item_t it;
    it = rand_item(MODE_WRITE);
    it.row    = row;
    it.column = column;
    it.length = length;
    pending_beats.push_back(it);
    beats_queued++;
  endtask

  task automatic push_clear();
    pending_beats.push_back(rand_item(MODE_CLEAR));
    beats_queued++;
  endtask

  task automatic push_noise();
    logic [1:0] m;
    m = 2'($urandom_range(0, 3));
    case (m)
      MODE_TICK:  push_ticks(1);
      MODE_WRITE: push_write(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), pick_length());
      MODE_CLEAR: push_clear();
      default:    push_load(pick_slot(), 8'($urandom_range(0, 255)));
    endcase
  endtask

  // ticks for a running request, with stray beats mixed in now and then
  task automatic push_busy_ticks(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 6) push_noise();
      push_ticks(1);
    end
  endtask

  task automatic gen_traffic(int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [5:0]  len;
    stop_at = beats_queued + budget;
    while (beats_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 4)) push_load(pick_slot(), 8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        len = pick_length();
        push_write(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), len);
        push_busy_ticks(2 * ((len > MaxLen) ? MaxLen : len) + 3 + $urandom_range(0, 3));
      end else if (pick < 75) begin
        push_clear();
        push_busy_ticks(mdl_clear_delay + 3 + $urandom_range(0, 3));
      end else begin
        repeat ($urandom_range(1, 6)) push_noise();
      end
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_INIT_DELAY) mdl_init_delay = value;
    else mdl_clear_delay = value;
    @(negedge clk_i);
  endtask

  // sender holds back until every expected beat is back
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid || expected_pins_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // power-up with a short wait; requests before ready are dropped
    write_reg(CFG_INIT_DELAY, 8'd3);
    push_write(1'b1, 6'd63, 6'd0);
    push_clear();
    push_load(5'd0, 8'h00);
    push_load(5'd1, 8'hFF);
    push_load(5'd2, 8'h55);
    push_load(5'd3, 8'hAA);
    push_load(5'd31, 8'h7E);
    push_ticks(3);
    wait_quiet();

    // wait count already past the lowered limit: wait ends on the next tick
    write_reg(CFG_INIT_DELAY, 8'd1);
    write_reg(CFG_CLEAR_DELAY, 8'd0);
    push_ticks(13);
    push_write(1'b1, 6'd63, 6'd0);
    push_ticks(3);
    push_write(1'b0, 6'd0, 6'd4);
    push_ticks(4);
    push_clear();
    push_write(1'b1, 6'd5, 6'd0);
    push_ticks(7);
    push_clear();
    push_ticks(3);
    wait_quiet();

    write_reg(CFG_INIT_DELAY, 8'd255);
    gen_traffic(PhaseBeats);
    wait_quiet();

    tx_idle_pct = 46;
    write_reg(CFG_CLEAR_DELAY, 8'd255);
    gen_traffic(PhaseBeats);
    wait_quiet();

    tx_idle_pct  = 0;
    rx_stall_pct = 46;
    write_reg(CFG_CLEAR_DELAY, 8'($urandom_range(1, 40)));
    write_reg(CFG_INIT_DELAY, 8'd0);
    gen_traffic(PhaseBeats);
    wait_quiet();

    tx_idle_pct  = 31;
    rx_stall_pct = 31;
    write_reg(CFG_CLEAR_DELAY, DELAY_RESET);
    write_reg(CFG_INIT_DELAY, 8'($urandom_range(0, 255)));
    gen_traffic(PhaseBeats);
    wait_quiet();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
